// ===== design/lc3b_pkg.sv =====
package lc3b_pkg;

  typedef enum logic [2:0] {
    ACT_WRITE = 3'd0,
    ACT_STEP  = 3'd1,
    ACT_READ  = 3'd2,
    ACT_REG   = 3'd3,
    ACT_START = 3'd4
  } action_e;

  typedef enum logic [3:0] {
    OP_BR   = 4'd0,
    OP_ADD  = 4'd1,
    OP_LDB  = 4'd2,
    OP_STB  = 4'd3,
    OP_JSR  = 4'd4,
    OP_AND  = 4'd5,
    OP_LDW  = 4'd6,
    OP_STW  = 4'd7,
    OP_XOR  = 4'd9,
    OP_JMP  = 4'd12,
    OP_SHF  = 4'd13,
    OP_LEA  = 4'd14,
    OP_TRAP = 4'd15
  } opcode_e;

  localparam logic [2:0] FLAG_N = 3'b100;
  localparam logic [2:0] FLAG_Z = 3'b010;
  localparam logic [2:0] FLAG_P = 3'b001;

  // Memory port request from the sequencer to the memory.
  typedef struct packed {
    logic        rd;
    logic        wr;
    logic [14:0] addr;
    logic [15:0] wdata;
    logic [1:0]  be;
  } mem_req_t;

  function automatic logic [2:0] cc_of(input logic [15:0] v);
    if (v == 16'h0000) return FLAG_Z;
    else if (v[15]) return FLAG_N;
    else return FLAG_P;
  endfunction

endpackage

// ===== design/lc3b_mem.sv =====
module lc3b_mem #(
  parameter int MemWords = 32768
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lc3b_pkg::mem_req_t  req_i,
  output logic [15:0]         rdata_o,
  output logic                clr_busy_o
);
  localparam int AW = $clog2(MemWords);

  logic [15:0] mem [MemWords];
  logic [AW-1:0] clr_q;
  logic          busy_q;
  logic [AW-1:0] a;

  assign a = req_i.addr[AW-1:0];
  assign clr_busy_o = busy_q;

  // Clearing pass after reset: one word per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      busy_q <= 1'b1;
    end else if (busy_q) begin
      clr_q <= clr_q + 1'b1;
      if (clr_q == AW'(MemWords - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_q] <= '0;
    end else if (req_i.wr) begin
      if (req_i.be[0]) mem[a][7:0]  <= req_i.wdata[7:0];
      if (req_i.be[1]) mem[a][15:8] <= req_i.wdata[15:8];
    end
    if (req_i.rd) rdata_o <= mem[a];
  end
endmodule

// ===== design/lc3b_seq.sv =====
module lc3b_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         action_i,
  input  logic [15:0]        address_i,
  input  logic [15:0]        data_i,
  input  logic [2:0]         reg_index_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        read_data_o,
  output logic [15:0]        pc_value_o,
  output logic               flag_neg_o,
  output logic               flag_zero_o,
  output logic               flag_pos_o,
  output logic               halted_o,
  output logic [31:0]        executed_count_o,
  input  logic               clr_busy_i,
  output lc3b_pkg::mem_req_t req_o,
  input  logic [15:0]        rdata_i
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_DATA  = 3'd3;
  localparam logic [2:0] S_RDW   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]  state_q, state_d;
  logic [15:0] rf_q [8];
  logic [15:0] pc_q, pc_d;
  logic [2:0]  cc_q, cc_d;
  logic        halt_q, halt_d;
  logic [31:0] cnt_q, cnt_d;
  logic [15:0] ir_q, ir_d;
  logic [15:0] ad_q, ad_d;
  logic [15:0] rd_q, rd_d;
  logic        rf_we;
  logic [2:0]  rf_wa;
  logic [15:0] rf_wd;
  logic        ovalid_q, ovalid_d;

  logic [3:0]  op;
  logic [2:0]  dr;
  logic [15:0] a, opnd, npc, off6, off6w, brt, res, shf;
  logic [7:0]  byt;

  assign op    = ir_q[15:12];
  assign dr    = ir_q[11:9];
  assign a     = rf_q[ir_q[8:6]];
  assign opnd  = ir_q[5] ? {{11{ir_q[4]}}, ir_q[4:0]} : rf_q[ir_q[2:0]];
  assign npc   = pc_q + 16'd2;
  assign off6  = {{10{ir_q[5]}}, ir_q[5:0]};
  assign off6w = {off6[14:0], 1'b0};
  assign brt   = npc + {{6{ir_q[8]}}, ir_q[8:0], 1'b0};
  assign byt   = ad_q[0] ? rdata_i[15:8] : rdata_i[7:0];

  always_comb begin
    if (!ir_q[4]) shf = a << ir_q[3:0];
    else if (ir_q[5] && a[15]) shf = ~((~a) >> ir_q[3:0]);
    else shf = a >> ir_q[3:0];
  end

  assign in_stall_o = (state_q != S_IDLE) || clr_busy_i;
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d  = state_q;
    pc_d     = pc_q;
    cc_d     = cc_q;
    halt_d   = halt_q;
    cnt_d    = cnt_q;
    ir_d     = ir_q;
    ad_d     = ad_q;
    rd_d     = rd_q;
    ovalid_d = ovalid_q;
    rf_we    = 1'b0;
    rf_wa    = dr;
    rf_wd    = '0;
    res      = '0;
    req_o    = '0;
    if (ovalid_q && !out_stall_i) ovalid_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && !clr_busy_i) begin
          rd_d  = '0;
          ad_d  = address_i;
          state_d = S_OUT;
          unique case (action_i)
            lc3b_pkg::ACT_WRITE: begin
              req_o.wr = 1'b1; req_o.addr = address_i[15:1];
              req_o.wdata = data_i; req_o.be = 2'b11;
            end
            lc3b_pkg::ACT_STEP: begin
              if (!halt_q) begin
                if (pc_q == 16'h0000) halt_d = 1'b1;
                else begin
                  req_o.rd = 1'b1; req_o.addr = pc_q[15:1]; state_d = S_FETCH;
                end
              end
            end
            lc3b_pkg::ACT_READ: begin
              req_o.rd = 1'b1; req_o.addr = address_i[15:1]; state_d = S_RDW;
            end
            lc3b_pkg::ACT_REG: rd_d = rf_q[reg_index_i];
            lc3b_pkg::ACT_START: begin
              pc_d = address_i; cc_d = lc3b_pkg::FLAG_Z; halt_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_RDW: begin
        rd_d = rdata_i;
        state_d = S_OUT;
      end
      S_FETCH: begin
        ir_d = rdata_i;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        pc_d  = npc;
        cnt_d = cnt_q + 32'd1;
        state_d = S_OUT;
        unique case (op) inside
          lc3b_pkg::OP_BR: if (|(dr & cc_q)) pc_d = brt;
          lc3b_pkg::OP_ADD, lc3b_pkg::OP_AND, lc3b_pkg::OP_XOR, lc3b_pkg::OP_SHF: begin
            case (op)
              lc3b_pkg::OP_ADD: res = a + opnd;
              lc3b_pkg::OP_AND: res = a & opnd;
              lc3b_pkg::OP_XOR: res = a ^ opnd;
              default:          res = shf;
            endcase
            rf_we = 1'b1; rf_wd = res; cc_d = lc3b_pkg::cc_of(res);
          end
          lc3b_pkg::OP_LDB, lc3b_pkg::OP_STB, lc3b_pkg::OP_LDW, lc3b_pkg::OP_STW: begin
            // The data access is issued here; load data returns in the next state.
            ad_d = (op == lc3b_pkg::OP_LDB || op == lc3b_pkg::OP_STB) ? a + off6 : a + off6w;
            req_o.addr = ad_d[15:1];
            state_d = S_DATA;
            if (op == lc3b_pkg::OP_STB) begin
              req_o.wr = 1'b1; req_o.wdata = {rf_q[dr][7:0], rf_q[dr][7:0]};
              req_o.be = ad_d[0] ? 2'b10 : 2'b01;
              state_d = S_OUT;
            end else if (op == lc3b_pkg::OP_STW) begin
              req_o.wr = 1'b1; req_o.wdata = rf_q[dr]; req_o.be = 2'b11;
              state_d = S_OUT;
            end else begin
              req_o.rd = 1'b1;
            end
          end
          lc3b_pkg::OP_JSR: begin
            pc_d = ir_q[11] ? npc + {{4{ir_q[10]}}, ir_q[10:0], 1'b0} : a;
            rf_we = 1'b1; rf_wa = 3'd7; rf_wd = npc;
          end
          lc3b_pkg::OP_JMP: pc_d = a;
          lc3b_pkg::OP_LEA: begin
            rf_we = 1'b1; rf_wd = brt;
          end
          lc3b_pkg::OP_TRAP: begin
            rf_we = 1'b1; rf_wa = 3'd7; rf_wd = npc;
            req_o.rd = 1'b1; req_o.addr = {7'd0, ir_q[7:0]};
            state_d = S_DATA;
          end
          default: ;
        endcase
      end
      S_DATA: begin
        state_d = S_OUT;
        if (op == lc3b_pkg::OP_TRAP) pc_d = rdata_i;
        else begin
          res = (op == lc3b_pkg::OP_LDB) ? {{8{byt[7]}}, byt} : rdata_i;
          rf_we = 1'b1; rf_wd = res; cc_d = lc3b_pkg::cc_of(res);
        end
      end
      S_OUT: begin
        if (!ovalid_q || !out_stall_i) begin
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pc_q     <= '0;
      cc_q     <= lc3b_pkg::FLAG_Z;
      halt_q   <= 1'b0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
      for (int i = 0; i < 8; i++) rf_q[i] <= '0;
    end else begin
      state_q  <= state_d;
      pc_q     <= pc_d;
      cc_q     <= cc_d;
      halt_q   <= halt_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
      if (rf_we) rf_q[rf_wa] <= rf_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    ir_q <= ir_d;
    ad_q <= ad_d;
    rd_q <= rd_d;
    if (state_q == S_OUT && (!ovalid_q || !out_stall_i)) begin
      read_data_o      <= rd_q;
      pc_value_o       <= pc_q;
      flag_neg_o       <= cc_q[2];
      flag_zero_o      <= cc_q[1];
      flag_pos_o       <= cc_q[0];
      halted_o         <= halt_q;
      executed_count_o <= cnt_q;
    end
  end
endmodule

// ===== design/lc3b_instruction_core.sv =====
// LC-3b instruction core.
// Input channel (in_valid_i / in_stall_o) carries one command per transaction:
// write a memory word, execute one instruction, read a memory word, read a
// register, or start at a PC. Each command yields exactly one result
// transaction on the output channel (out_valid_o / out_stall_i) showing the
// read data, PC, N/Z/P flags, halt flag and executed instruction count.
// Register reads, writes, starts and steps that halt or are halted go straight
// to output; memory reads pass a read-data state; ALU, branch, jump and store
// steps fetch, then execute; byte and word loads and TRAP add a data state.
// The sequence is set by the single-port memory: fetch, then a data access.
// One command is in flight at a time; the next is accepted in the cycle after
// the result is loaded. The result register lets that happen while the last
// result still waits. After reset the memory is cleared one word per cycle,
// all MEM_WORDS words, while in_stall_o stays high. A stalled result holds until
// taken; a finished command waits for the output register before issuing its
// result.
module lc3b_instruction_core #(
  parameter int MEM_WORDS = 32768
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  action_i,
  input  logic [15:0] address_i,
  input  logic [15:0] data_i,
  input  logic [2:0]  reg_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] read_data_o,
  output logic [15:0] pc_value_o,
  output logic        flag_neg_o,
  output logic        flag_zero_o,
  output logic        flag_pos_o,
  output logic        halted_o,
  output logic [31:0] executed_count_o
);
  lc3b_pkg::mem_req_t req;
  logic [15:0]        rdata;
  logic               clr_busy;

  lc3b_mem #(.MemWords(MEM_WORDS)) u_mem (
    .clk_i, .rst_ni, .req_i(req), .rdata_o(rdata), .clr_busy_o(clr_busy)
  );

  lc3b_seq u_seq (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .action_i, .address_i, .data_i,
    .reg_index_i, .out_valid_o, .out_stall_i, .read_data_o, .pc_value_o,
    .flag_neg_o, .flag_zero_o, .flag_pos_o, .halted_o, .executed_count_o,
    .clr_busy_i(clr_busy), .req_o(req), .rdata_i(rdata)
  );
endmodule

// ===== design/lc3b_checker.sv =====
module lc3b_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] executed_count_o
);
  // A result is held while stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(executed_count_o))
    else $error("stalled result changed");
  // An accepted command cannot be followed by another acceptance next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("back-to-back acceptance");
  // Count advances by at most one between results that follow each other directly.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i ##1 out_valid_o && $changed(executed_count_o) |->
      executed_count_o == $past(executed_count_o) + 32'd1)
    else $error("count jumped");
endmodule

bind lc3b_instruction_core lc3b_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .executed_count_o
);

// ===== dv/lc3b_instruction_core_test.sv =====
`timescale 1ns / 100ps

module lc3b_instruction_core_test;

  localparam int ModelWords = 32768;
  localparam int CycleLimit = 600000;
  localparam logic [2:0] ACT_NONE5 = 3'd5;
  localparam logic [2:0] ACT_NONE7 = 3'd7;

  typedef struct {
    logic [2:0]  act;
    logic [15:0] addr;
    logic [15:0] data;
    logic [2:0]  ri;
    bit          drain;
  } command_t;

  typedef struct {
    logic [15:0] rdata;
    logic [15:0] pc;
    logic        n;
    logic        z;
    logic        p;
    logic        halt;
    logic [31:0] count;
  } core_view_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  action_i = '0;
  logic [15:0] address_i = '0;
  logic [15:0] data_i = '0;
  logic [2:0]  reg_index_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] read_data_o;
  logic [15:0] pc_value_o;
  logic        flag_neg_o;
  logic        flag_zero_o;
  logic        flag_pos_o;
  logic        halted_o;
  logic [31:0] executed_count_o;

  lc3b_instruction_core uut (.*);

  always #5 clk_i = ~clk_i;

  // Shadow copy of the architectural state.
  logic [15:0] cpu_reg [8];
  logic [15:0] cpu_mem [ModelWords];
  logic [15:0] cpu_pc;
  logic [2:0]  cpu_cc;
  logic        cpu_halt;
  logic [31:0] cpu_count;

  command_t   pending_q[$];
  core_view_t expected_q[$];
  int         n_errors = 0;
  int         n_items = 0;
  int         n_accepted = 0;
  int         cycles = 0;

  function automatic logic [15:0] sext(input logic [15:0] v, input int bits);
    logic [15:0] m;
    m = (16'h1 << bits) - 16'h1;
    v = v & m;
    if (v[bits-1]) v = v | ~m;
    return v;
  endfunction

  function automatic void update_cc(input logic [15:0] v);
    if (v == 16'h0000) cpu_cc = lc3b_pkg::FLAG_Z;
    else if (v[15]) cpu_cc = lc3b_pkg::FLAG_N;
    else cpu_cc = lc3b_pkg::FLAG_P;
  endfunction

  function automatic void execute_instruction();
    logic [15:0] ir, npc, opnd, a, res, ad, w, link;
    logic [2:0]  dr;
    logic [14:0] wi;
    ir = cpu_mem[cpu_pc[15:1]];
    npc = cpu_pc + 16'd2;
    dr = ir[11:9];
    opnd = ir[5] ? sext(ir, 5) : cpu_reg[ir[2:0]];
    a = cpu_reg[ir[8:6]];
    case (ir[15:12])
      lc3b_pkg::OP_BR: begin
        if ((ir[11:9] & cpu_cc) != 3'b000) npc = npc + (sext(ir, 9) << 1);
      end
      lc3b_pkg::OP_ADD: begin
        res = a + opnd;
        cpu_reg[dr] = res;
        update_cc(res);
      end
      lc3b_pkg::OP_LDB: begin
        ad = a + sext(ir, 6);
        w = cpu_mem[ad[15:1]];
        res = sext(ad[0] ? {8'h00, w[15:8]} : {8'h00, w[7:0]}, 8);
        cpu_reg[dr] = res;
        update_cc(res);
      end
      lc3b_pkg::OP_STB: begin
        ad = a + sext(ir, 6);
        wi = ad[15:1];
        if (ad[0]) cpu_mem[wi] = {cpu_reg[dr][7:0], cpu_mem[wi][7:0]};
        else cpu_mem[wi] = {cpu_mem[wi][15:8], cpu_reg[dr][7:0]};
      end
      lc3b_pkg::OP_JSR: begin
        link = npc;
        if (ir[11]) npc = npc + (sext(ir, 11) << 1);
        else npc = a;
        cpu_reg[7] = link;
      end
      lc3b_pkg::OP_AND: begin
        res = a & opnd;
        cpu_reg[dr] = res;
        update_cc(res);
      end
      lc3b_pkg::OP_LDW: begin
        ad = a + (sext(ir, 6) << 1);
        res = cpu_mem[ad[15:1]];
        cpu_reg[dr] = res;
        update_cc(res);
      end
      lc3b_pkg::OP_STW: begin
        ad = a + (sext(ir, 6) << 1);
        cpu_mem[ad[15:1]] = cpu_reg[dr];
      end
      lc3b_pkg::OP_XOR: begin
        res = a ^ opnd;
        cpu_reg[dr] = res;
        update_cc(res);
      end
      lc3b_pkg::OP_JMP: npc = a;
      lc3b_pkg::OP_SHF: begin
        if (!ir[4]) res = a << ir[3:0];
        else if (ir[5] && a[15]) res = ~((~a) >> ir[3:0]);
        else res = a >> ir[3:0];
        cpu_reg[dr] = res;
        update_cc(res);
      end
      lc3b_pkg::OP_LEA: cpu_reg[dr] = npc + (sext(ir, 9) << 1);
      lc3b_pkg::OP_TRAP: begin
        cpu_reg[7] = npc;
        npc = cpu_mem[{7'd0, ir[7:0]}];
      end
      default: ;
    endcase
    cpu_pc = npc;
    cpu_count = cpu_count + 32'd1;
  endfunction

  function automatic core_view_t apply_command(input logic [2:0] act, input logic [15:0] addr,
                                               input logic [15:0] data, input logic [2:0] ri);
    core_view_t v;
    v.rdata = 16'h0000;
    case (act)
      lc3b_pkg::ACT_WRITE: cpu_mem[addr[15:1]] = data;
      lc3b_pkg::ACT_STEP: if (!cpu_halt) begin
        if (cpu_pc == 16'h0000) cpu_halt = 1'b1;
        else execute_instruction();
      end
      lc3b_pkg::ACT_READ: v.rdata = cpu_mem[addr[15:1]];
      lc3b_pkg::ACT_REG: v.rdata = cpu_reg[ri];
      lc3b_pkg::ACT_START: begin
        cpu_pc = addr;
        cpu_cc = lc3b_pkg::FLAG_Z;
        cpu_halt = 1'b0;
      end
      default: ;
    endcase
    v.pc = cpu_pc;
    v.n = cpu_cc[2];
    v.z = cpu_cc[1];
    v.p = cpu_cc[0];
    v.halt = cpu_halt;
    v.count = cpu_count;
    return v;
  endfunction

  function automatic void push_command(input logic [2:0] act, input logic [15:0] addr,
                                       input logic [15:0] data, input logic [2:0] ri);
    command_t c;
    c.act = act;
    c.addr = addr;
    c.data = data;
    c.ri = ri;
    c.drain = 1'b0;
    pending_q.push_back(c);
    n_items++;
  endfunction

  function automatic void push_drain();
    command_t c;
    c = '{default: '0};
    c.drain = 1'b1;
    pending_q.push_back(c);
  endfunction

  function automatic logic [15:0] random_instruction();
    logic [3:0] op;
    op = 4'($urandom_range(0, 15));
    return {op, 12'($urandom)};
  endfunction

  // Mostly no gap, some short ones, a few long; every other stretch has none.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (((n_accepted / 150) % 2) == 1) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    n_errors++;
  endtask

  // Driver: one transaction offered at a time, gaps inserted after each.
  int gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_q.push_back(apply_command(action_i, address_i, data_i, reg_index_i));
        n_accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        while (pending_q.size() > 0 && pending_q[0].drain && expected_q.size() == 0)
          void'(pending_q.pop_front());
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() > 0 && !pending_q[0].drain) begin
          command_t c;
          c = pending_q.pop_front();
          action_i <= c.act;
          address_i <= c.addr;
          data_i <= c.data;
          reg_index_i <= c.ri;
          in_valid_i <= 1'b1;
          gap_left = pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stalls, with one long hold-off so the core backs up.
  int stall_left;
  int hold_left;
  bit held_once;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
      hold_left = 0;
      held_once = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (!held_once && n_accepted > 300) begin
      held_once = 1'b1;
      hold_left = 400;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      stall_left = pick_gap();
      out_stall_i <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Monitor: each result transaction against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", 32'(pc_value_o), 32'h0);
      end else begin
        core_view_t e;
        e = expected_q.pop_front();
        if (read_data_o !== e.rdata) report_mismatch("read_data", 32'(read_data_o), 32'(e.rdata));
        if (pc_value_o !== e.pc) report_mismatch("pc_value", 32'(pc_value_o), 32'(e.pc));
        if (flag_neg_o !== e.n) report_mismatch("flag_neg", 32'(flag_neg_o), 32'(e.n));
        if (flag_zero_o !== e.z) report_mismatch("flag_zero", 32'(flag_zero_o), 32'(e.z));
        if (flag_pos_o !== e.p) report_mismatch("flag_pos", 32'(flag_pos_o), 32'(e.p));
        if (halted_o !== e.halt) report_mismatch("halted", 32'(halted_o), 32'(e.halt));
        if (executed_count_o !== e.count)
          report_mismatch("executed_count", executed_count_o, e.count);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [15:0] base;
    int k;
    for (int i = 0; i < 8; i++) cpu_reg[i] = 16'h0000;
    for (int i = 0; i < ModelWords; i++) cpu_mem[i] = 16'h0000;
    cpu_pc = 16'h0000;
    cpu_cc = lc3b_pkg::FLAG_Z;
    cpu_halt = 1'b0;
    cpu_count = 32'd0;

    // Step at PC zero halts; a second step is ignored while halted.
    push_command(lc3b_pkg::ACT_STEP, 16'h0000, 16'h0000, 3'd0);
    push_command(lc3b_pkg::ACT_STEP, 16'hFFFF, 16'hFFFF, 3'd7);
    push_command(lc3b_pkg::ACT_REG, 16'h0000, 16'h0000, 3'd7);
    push_command(ACT_NONE5, 16'hFFFF, 16'hFFFF, 3'd7);
    push_command(ACT_NONE7, 16'h1234, 16'h5678, 3'd3);
    // An odd byte address selects the word below it, here the top word.
    push_command(lc3b_pkg::ACT_WRITE, 16'hFFFF, 16'hFFFF, 3'd0);
    push_command(lc3b_pkg::ACT_READ, 16'hFFFE, 16'h0000, 3'd0);
    push_command(lc3b_pkg::ACT_WRITE, 16'h000A, 16'h0200, 3'd0);
    push_command(lc3b_pkg::ACT_WRITE, 16'h0100, 16'h127F, 3'd0);
    push_command(lc3b_pkg::ACT_WRITE, 16'h0102, 16'h0000, 3'd0);
    push_command(lc3b_pkg::ACT_WRITE, 16'h0104, 16'h8000, 3'd0);
    push_command(lc3b_pkg::ACT_WRITE, 16'h0106, 16'hE5FD, 3'd0);
    push_command(lc3b_pkg::ACT_WRITE, 16'h0108, 16'hD4B3, 3'd0);
    push_command(lc3b_pkg::ACT_WRITE, 16'h010A, 16'hF005, 3'd0);
    push_command(lc3b_pkg::ACT_START, 16'h0101, 16'h0000, 3'd0);
    for (int i = 0; i < 7; i++) push_command(lc3b_pkg::ACT_STEP, 16'h0000, 16'h0000, 3'd0);
    push_command(lc3b_pkg::ACT_REG, 16'h0000, 16'h0000, 3'd2);
    push_drain();

    while (n_items < 1650) begin
      if ($urandom_range(0, 9) < 8) begin
        base = 16'($urandom) & 16'hFFFE;
        k = $urandom_range(4, 12);
        for (int i = 0; i < k; i++)
          push_command(lc3b_pkg::ACT_WRITE, base + 16'(2 * i), random_instruction(),
                       3'($urandom));
        if ($urandom_range(0, 2) == 0)
          push_command(lc3b_pkg::ACT_WRITE, 16'($urandom_range(0, 255) * 2),
                       16'($urandom) & 16'hFFFE, 3'($urandom));
        push_command(lc3b_pkg::ACT_START, base | 16'($urandom_range(0, 1)), 16'($urandom),
                     3'($urandom));
        k = $urandom_range(5, 25);
        for (int i = 0; i < k; i++)
          push_command(lc3b_pkg::ACT_STEP, 16'($urandom), 16'($urandom), 3'($urandom));
        push_command(lc3b_pkg::ACT_REG, 16'($urandom), 16'($urandom), 3'($urandom));
        push_command(lc3b_pkg::ACT_READ, 16'($urandom), 16'($urandom), 3'($urandom));
        if ($urandom_range(0, 19) == 0) push_drain();
      end else begin
        push_command(3'($urandom), 16'($urandom), 16'($urandom), 3'($urandom));
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_q.size() == 0 && !in_valid_i && expected_q.size() == 0);
    repeat (50) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
